>>> sv/qbt_pkg.sv
// Package for the quoted bracket tokenizer: request and result types,
// lexer modes, result kinds and character codes. No dependencies.
package qbt_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  localparam logic [7:0] CH_OPEN   = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE  = 8'h5D;  // ]
  localparam logic [7:0] CH_QUOTE  = 8'h22;  // "
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ATOM    = 3'd1,
    MODE_BRACKET = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_ERROR   = 3'd5
  } mode_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tok_char;
    logic       last;
  } res_t;

  // One classified request: its first result, and whether a line-done
  // result follows it.
  typedef struct packed {
    logic       two;
    logic [1:0] kind;
    logic [7:0] tok_char;
  } job_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

>>> sv/quoted_bracket_tokenizer_core.sv
// Quoted bracket tokenizer, top level: front end, job queue and back end.
// Depends on qbt_pkg, qbt_front, qbt_queue and qbt_emit.
//
// Usage: the request channel (req_valid, req_stall, req) carries one line
// as character requests (cmd = 0, byte in ch) followed by an end-of-line
// request (cmd = 1). The result channel (res_valid, res_stall, res) gives
// token characters, token ends, parse errors and line done; last marks the
// final result of each request. Both sides transfer at an edge with valid
// high and stall low.
// Throughput: one request per cycle while req_stall is low. The output
// register holds one result at a time, so an end of line with an open
// token (two results) occupies it twice; the job queue absorbs the
// difference. The edge that accepts a request writes its job into the
// queue; a later edge loads the first result from the queue head into the
// output register, where it is shown until taken.
// Requests that produce no result never enter the queue.
// When the receiver stalls, the output holds and the queue fills; req_stall
// rises once the queue is full. Reset empties queue and output and puts the
// lexer between tokens.
module quoted_bracket_tokenizer_core import qbt_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic push, full, pop, avail;
  job_t push_job, head;

  assign req_stall = full;

  qbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .job       (push_job)
  );

  qbt_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  qbt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

>>> sv/qbt_front.sv
// Front end of the tokenizer: holds the lexer mode and turns each request
// into a job for the queue. Depends on qbt_pkg.
module qbt_front import qbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  output logic push,
  output job_t job
);

  mode_t lex_mode, lex_mode_next;
  logic  accept;

  assign accept = req_valid && !req_stall;

  always_comb begin
    lex_mode_next = lex_mode;
    if (req.cmd == CMD_EOL) begin
      lex_mode_next = MODE_IDLE;
    end else begin
      unique case (lex_mode)
        MODE_IDLE: begin
          if (is_space(req.ch)) lex_mode_next = MODE_IDLE;
          else if (req.ch == CH_QUOTE) lex_mode_next = MODE_STRING;
          else if (req.ch == CH_CLOSE) lex_mode_next = MODE_ERROR;
          else if (req.ch == CH_OPEN) lex_mode_next = MODE_BRACKET;
          else lex_mode_next = MODE_ATOM;
        end
        MODE_ATOM: begin
          if (is_space(req.ch)) lex_mode_next = MODE_IDLE;
          else if (req.ch == CH_CLOSE) lex_mode_next = MODE_ERROR;
          else if (req.ch == CH_OPEN) lex_mode_next = MODE_BRACKET;
        end
        MODE_BRACKET: begin
          if (req.ch == CH_CLOSE) lex_mode_next = MODE_ATOM;
        end
        MODE_STRING: begin
          if (req.ch == CH_QUOTE) lex_mode_next = MODE_IDLE;
          else if (req.ch == CH_BSLASH) lex_mode_next = MODE_ESCAPE;
        end
        MODE_ESCAPE: lex_mode_next = MODE_STRING;
        default:     lex_mode_next = MODE_ERROR;
      endcase
    end
  end

  always_comb begin
    logic emit;
    emit = 1'b0;
    job  = '{two: 1'b0, kind: KIND_CHAR, tok_char: 8'h00};
    if (req.cmd == CMD_EOL) begin
      emit = 1'b1;
      job.kind = KIND_DONE;
      if (lex_mode == MODE_ATOM || lex_mode == MODE_BRACKET || lex_mode == MODE_STRING) begin
        job.two  = 1'b1;
        job.kind = KIND_END;
      end else if (lex_mode == MODE_ESCAPE) begin
        job.two  = 1'b1;
        job.kind = KIND_ERROR;
      end
    end else begin
      unique case (lex_mode)
        MODE_IDLE, MODE_ATOM: begin
          if (is_space(req.ch)) begin
            emit     = (lex_mode == MODE_ATOM);
            job.kind = KIND_END;
          end else if (req.ch == CH_CLOSE) begin
            emit     = 1'b1;
            job.kind = KIND_ERROR;
          end else if (!(lex_mode == MODE_IDLE && req.ch == CH_QUOTE)) begin
            emit         = 1'b1;
            job.tok_char = req.ch;
          end
        end
        MODE_BRACKET, MODE_ESCAPE: begin
          emit         = 1'b1;
          job.tok_char = req.ch;
        end
        MODE_STRING: begin
          if (req.ch == CH_QUOTE) begin
            emit     = 1'b1;
            job.kind = KIND_END;
          end else if (req.ch != CH_BSLASH) begin
            emit         = 1'b1;
            job.tok_char = req.ch;
          end
        end
        default: emit = 1'b0;
      endcase
    end
    push = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= MODE_IDLE;
    end else if (accept) begin
      lex_mode <= lex_mode_next;
    end
  end

  // Bytes in error mode are dropped without a trace.
  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    (lex_mode == MODE_ERROR && req.cmd == CMD_CHAR) |-> !push)
    else $error("request in error mode produced a result");
  // Every end of line produces at least the line-done result.
  a_eol_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_EOL) |-> push)
    else $error("end of line produced no result");
  // The mode is idle after any end of line.
  a_eol_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_EOL) |=> lex_mode == MODE_IDLE)
    else $error("mode not idle after end of line");

endmodule

>>> sv/qbt_queue.sv
// Short job queue between the tokenizer front and back, held in
// flip-flops. Depends on qbt_pkg.
module qbt_queue import qbt_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full    = (count == Full);
  assign avail   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= Full)
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("pop from an empty queue");

endmodule

>>> sv/qbt_emit.sv
// Back end of the tokenizer: takes jobs from the queue and presents the
// results through an output register, one per unstalled cycle. Depends on qbt_pkg.
module qbt_emit import qbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic avail,
  input  job_t head,
  output logic pop,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic load;
  logic pending;  // a line-done result still owed for the last job

  assign load = !res_valid || !res_stall;
  assign pop  = load && !pending && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        res_valid <= 1'b1;
        pending   <= 1'b0;
      end else begin
        res_valid <= avail;
        pending   <= avail && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        res <= '{kind: KIND_DONE, tok_char: 8'h00, last: 1'b1};
      end else if (avail) begin
        res <= '{kind: head.kind, tok_char: head.tok_char, last: !head.two};
      end
    end
  end

  // A result that is not the last of its request is followed by line done.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !res.last) |=> (res_valid && res.kind == KIND_DONE))
    else $error("missing line-done result");
  a_pending_valid: assert property (@(posedge clk) disable iff (rst)
    pending |-> res_valid)
    else $error("owed result with empty output register");
  a_no_pop_pending: assert property (@(posedge clk) disable iff (rst)
    pending |-> !pop)
    else $error("job taken while a result is still owed");

endmodule

>>> tb/tb_quoted_bracket_tokenizer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for quoted_bracket_tokenizer_core: random lines of text
// with an in-bench tokenizer predictor. Depends on qbt_pkg and the core.
module tb_quoted_bracket_tokenizer_core;
  import qbt_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam int PRESS_FROM = 300;
  localparam int PRESS_TO   = 380;

  typedef struct packed {
    logic       drain;
    logic [4:0] gap;
    req_t       payload;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  stim_t stim_q[$];
  res_t  expected_tokens[$];
  mode_t lex_state = MODE_IDLE;

  stim_t       staged_item;
  logic        staged = 1'b0;
  logic        launch;
  int unsigned gap_left;
  int unsigned reqs_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left;
  int unsigned long_left;
  logic        long_done = 1'b0;
  logic        long_hold = 1'b0;
  res_t        want;
  int          errors = 0;
  int          n_items = 0;
  int          lines = 0;
  int          gap_style = 0;
  logic        drain_next = 1'b0;

  quoted_bracket_tokenizer_core dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always #2 clk = ~clk;

  function automatic bit blank_byte(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Random byte, half the time printable, avoiding up to three given codes.
  function automatic logic [7:0] text_byte(input bit blanks_ok, input logic [7:0] x1,
                                           input logic [7:0] x2, input logic [7:0] x3);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 1) == 1) b = 8'($urandom_range(33, 126));
      else b = 8'($urandom_range(0, 255));
    end while ((!blanks_ok && blank_byte(b)) || b == x1 || b == x2 || b == x3);
    return b;
  endfunction

  function automatic res_t token_out(input logic [1:0] k, input logic [7:0] c);
    res_t r;
    r.kind = k;
    r.tok_char = c;
    r.last = 1'b0;
    return r;
  endfunction

  // Advances the lexer state by one request and queues the results it gives.
  task automatic tokenize_step(input req_t r);
    res_t produced[$];
    if (r.cmd == CMD_EOL) begin
      if (lex_state == MODE_ATOM || lex_state == MODE_BRACKET || lex_state == MODE_STRING)
        produced = {produced, token_out(KIND_END, 8'h00)};
      else if (lex_state == MODE_ESCAPE)
        produced = {produced, token_out(KIND_ERROR, 8'h00)};
      produced = {produced, token_out(KIND_DONE, 8'h00)};
      lex_state = MODE_IDLE;
    end else begin
      case (lex_state)
        MODE_IDLE: begin
          if (blank_byte(r.ch)) begin
          end else if (r.ch == CH_QUOTE) begin
            lex_state = MODE_STRING;
          end else if (r.ch == CH_CLOSE) begin
            produced = {produced, token_out(KIND_ERROR, 8'h00)};
            lex_state = MODE_ERROR;
          end else begin
            produced = {produced, token_out(KIND_CHAR, r.ch)};
            lex_state = (r.ch == CH_OPEN) ? MODE_BRACKET : MODE_ATOM;
          end
        end
        MODE_ATOM: begin
          if (blank_byte(r.ch)) begin
            produced = {produced, token_out(KIND_END, 8'h00)};
            lex_state = MODE_IDLE;
          end else if (r.ch == CH_CLOSE) begin
            produced = {produced, token_out(KIND_ERROR, 8'h00)};
            lex_state = MODE_ERROR;
          end else begin
            produced = {produced, token_out(KIND_CHAR, r.ch)};
            if (r.ch == CH_OPEN) lex_state = MODE_BRACKET;
          end
        end
        MODE_BRACKET: begin
          produced = {produced, token_out(KIND_CHAR, r.ch)};
          if (r.ch == CH_CLOSE) lex_state = MODE_ATOM;
        end
        MODE_STRING: begin
          if (r.ch == CH_QUOTE) begin
            produced = {produced, token_out(KIND_END, 8'h00)};
            lex_state = MODE_IDLE;
          end else if (r.ch == CH_BSLASH) begin
            lex_state = MODE_ESCAPE;
          end else begin
            produced = {produced, token_out(KIND_CHAR, r.ch)};
          end
        end
        MODE_ESCAPE: begin
          produced = {produced, token_out(KIND_CHAR, r.ch)};
          lex_state = MODE_STRING;
        end
        default: begin
        end
      endcase
    end
    if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
    expected_tokens = {expected_tokens, produced};
  endtask

  task automatic put_byte(input logic cmd, input logic [7:0] b);
    stim_t s;
    logic  pressing;
    pressing = (n_items >= PRESS_FROM) && (n_items < PRESS_TO);
    s.payload.cmd = cmd;
    s.payload.ch = b;
    case (gap_style)
      0: s.gap = 5'd0;
      1: s.gap = 5'($urandom_range(0, 19));
      default: s.gap = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(1, 19)) : 5'd0;
    endcase
    // The sender keeps offering back to back while the receiver holds off.
    if (pressing) s.gap = 5'd0;
    s.drain = drain_next && !pressing;
    drain_next = 1'b0;
    stim_q = {stim_q, s};
    n_items++;
  endtask

  task automatic add_line();
    int         ntok;
    int         nch;
    int         tail;
    logic [7:0] b;
    gap_style = $urandom_range(0, 2);
    if ($urandom_range(0, 6) == 0) begin
      nch = $urandom_range(1, 10);
      repeat (nch) begin
        if ($urandom_range(0, 1) == 1) begin
          b = 8'($urandom_range(0, 255));
        end else begin
          case ($urandom_range(0, 4))
            0: b = CH_OPEN;
            1: b = CH_CLOSE;
            2: b = CH_QUOTE;
            3: b = CH_BSLASH;
            default: b = CH_SPACE;
          endcase
        end
        put_byte(CMD_CHAR, b);
      end
    end else begin
      if ($urandom_range(0, 3) == 0) put_byte(CMD_CHAR, pick_blank());
      ntok = $urandom_range(1, 5);
      for (int t = 0; t < ntok; t++) begin
        if ($urandom_range(0, 4) < 3) begin
          put_byte(CMD_CHAR, text_byte(1'b0, CH_QUOTE, CH_CLOSE, CH_OPEN));
          nch = $urandom_range(0, 5);
          repeat (nch) begin
            if ($urandom_range(0, 5) == 0) begin
              put_byte(CMD_CHAR, CH_OPEN);
              repeat ($urandom_range(0, 4))
                put_byte(CMD_CHAR, text_byte(1'b1, CH_CLOSE, CH_CLOSE, CH_CLOSE));
              put_byte(CMD_CHAR, CH_CLOSE);
            end else begin
              put_byte(CMD_CHAR, text_byte(1'b0, CH_CLOSE, CH_OPEN, CH_OPEN));
            end
          end
          if (t < ntok - 1 || $urandom_range(0, 1) == 1) put_byte(CMD_CHAR, pick_blank());
        end else begin
          put_byte(CMD_CHAR, CH_QUOTE);
          nch = $urandom_range(0, 6);
          repeat (nch) begin
            if ($urandom_range(0, 4) == 0) begin
              put_byte(CMD_CHAR, CH_BSLASH);
              put_byte(CMD_CHAR, 8'($urandom_range(0, 255)));
            end else begin
              put_byte(CMD_CHAR, text_byte(1'b1, CH_QUOTE, CH_BSLASH, CH_BSLASH));
            end
          end
          put_byte(CMD_CHAR, CH_QUOTE);
          // Without a blank, the next token starts straight after the quote.
          if ($urandom_range(0, 3) != 0) put_byte(CMD_CHAR, pick_blank());
        end
      end
      tail = $urandom_range(0, 9);
      case (tail)
        0: begin
          put_byte(CMD_CHAR, CH_QUOTE);
          repeat ($urandom_range(0, 3))
            put_byte(CMD_CHAR, text_byte(1'b1, CH_QUOTE, CH_BSLASH, CH_BSLASH));
        end
        1: begin
          put_byte(CMD_CHAR, CH_QUOTE);
          put_byte(CMD_CHAR, CH_BSLASH);
        end
        2: begin
          put_byte(CMD_CHAR, text_byte(1'b0, CH_QUOTE, CH_CLOSE, CH_OPEN));
          put_byte(CMD_CHAR, CH_OPEN);
        end
        default: begin
        end
      endcase
    end
    put_byte(CMD_EOL, 8'($urandom_range(0, 255)));
  endtask

  // Sender: a staged request waits out its gap, and optionally until nothing
  // is outstanding, before it is offered.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      staged = 1'b0;
      gap_left = 0;
    end else if (!(req_valid && req_stall)) begin
      if (req_valid) begin
        tokenize_step(req);
        reqs_accepted++;
      end
      if (!staged && stim_q.size() > 0) begin
        staged_item = stim_q.pop_front();
        staged = 1'b1;
        gap_left = staged_item.gap;
      end
      launch = staged && gap_left == 0 &&
               (!staged_item.drain || expected_tokens.size() == 0);
      if (staged && gap_left > 0) gap_left--;
      req_valid <= launch;
      if (launch) begin
        req <= staged_item.payload;
        staged = 1'b0;
      end
    end
  end

  // One long hold-off of the result channel, so that the queue fills and
  // the request side is stalled.
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 1'b0;
      long_left = 0;
    end else begin
      if (!long_done && reqs_accepted >= PRESS_FROM) begin
        long_left = 250;
        long_done = 1'b1;
      end else if (long_left > 0) begin
        long_left--;
      end
      long_hold <= (long_left > 0);
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result: kind %0d char %h last %b",
                   $time, res.kind, res.tok_char, res.last);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          if (res.kind !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, res.kind);
            errors++;
          end
          if (res.tok_char !== want.tok_char) begin
            $display("%0t: tok_char mismatch: expected %h actual %h",
                     $time, want.tok_char, res.tok_char);
            errors++;
          end
          if (res.last !== want.last) begin
            $display("%0t: last mismatch: expected %b actual %b", $time, want.last, res.last);
            errors++;
          end
        end
        // Quiet stretches with no random wait, random waits otherwise.
        hold_left = ((results_seen % 400) < 120) ? 0 : $urandom_range(0, 19);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      res_stall <= (hold_left > 0) || long_hold;
    end
  end

  initial begin
    // Directed line set: extreme bytes, brackets, stray closes, strings with
    // escapes, an empty string and the awkward endings of a line.
    gap_style = 0;
    put_byte(CMD_CHAR, 8'hFF);
    put_byte(CMD_CHAR, CH_QUOTE);
    put_byte(CMD_CHAR, CH_TAB);
    put_byte(CMD_CHAR, CH_OPEN);
    put_byte(CMD_CHAR, CH_SPACE);
    put_byte(CMD_CHAR, CH_CLOSE);
    put_byte(CMD_CHAR, CH_CLOSE);
    put_byte(CMD_CHAR, 8'h7A);
    put_byte(CMD_EOL, 8'h00);
    put_byte(CMD_CHAR, CH_QUOTE);
    put_byte(CMD_CHAR, CH_QUOTE);
    put_byte(CMD_CHAR, CH_QUOTE);
    put_byte(CMD_CHAR, CH_BSLASH);
    put_byte(CMD_CHAR, CH_QUOTE);
    put_byte(CMD_CHAR, 8'h00);
    put_byte(CMD_CHAR, CH_QUOTE);
    put_byte(CMD_CHAR, 8'h71);
    put_byte(CMD_CHAR, CH_CR);
    put_byte(CMD_CHAR, CH_OPEN);
    put_byte(CMD_EOL, 8'hFF);
    put_byte(CMD_CHAR, CH_CLOSE);
    put_byte(CMD_EOL, 8'h5A);
    put_byte(CMD_CHAR, CH_QUOTE);
    put_byte(CMD_CHAR, CH_BSLASH);
    put_byte(CMD_EOL, 8'hA5);
    drain_next = 1'b1;
    while (n_items < 1400) begin
      if (lines % 40 == 20) drain_next = 1'b1;
      add_line();
      lines++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (stim_q.size() > 0 || staged || req_valid || expected_tokens.size() > 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("quoted_bracket_tokenizer_core test passed");
    end else begin
      $display("quoted_bracket_tokenizer_core test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("quoted_bracket_tokenizer_core test failed");
    $finish;
  end

endmodule

>>> files.f
sv/qbt_pkg.sv
sv/qbt_front.sv
sv/qbt_queue.sv
sv/qbt_emit.sv
sv/quoted_bracket_tokenizer_core.sv
tb/tb_quoted_bracket_tokenizer_core.sv
